// File: design/y2r_pkg.sv
// Shared types, coefficients and the saturating divide-by-10000 for the YUV to RGB converter.
`timescale 1ns / 1ps
package y2r_pkg;

    typedef logic signed [23:0] t_num;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    // coefficients scaled by 10000
    localparam logic [13:0] KY_RB = 14'd11644;
    localparam logic [14:0] KY_G  = 15'd19837;
    localparam logic [13:0] KV_R  = 14'd15938;
    localparam logic [14:0] KU_B  = 15'd20238;
    localparam logic [12:0] KR_G  = 13'd5094;
    localparam logic [10:0] KB_G  = 11'd1942;

    localparam t_num OFF_R = 24'sd2221300;
    localparam t_num OFF_B = 24'sd2771300;
    localparam t_num OFF_G = 24'sd311710;

    // numerators at or above this give a quotient of 255 or more
    localparam t_num        DIV_LIM  = 24'sd2560000;
    // ceil(2^34 / 10000): exact for numerators below DIV_LIM
    localparam logic [20:0] RECIP    = 21'd1717987;
    localparam int          RECIP_SH = 34;
    localparam logic [7:0]  CHAN_MAX = 8'd255;

    // pipeline depth of one lane, in clock edges
    localparam int LANE_LAT = 5;

    function automatic logic [7:0] sat_div(input t_num num);
        logic [42:0] prod;
        logic [7:0]  res;
        prod = 43'(num[21:0]) * 43'(RECIP);
        if (num < 0) begin
            res = 8'd0;
        end else if (num >= DIV_LIM) begin
            res = CHAN_MAX;
        end else begin
            res = prod[RECIP_SH+7:RECIP_SH];
        end
        return res;
    endfunction

endpackage

// File: design/y2r_lane.sv
// One conversion lane: five-stage pipeline turning Y, U, V into one RGB888 pixel.
`timescale 1ns / 1ps
module y2r_lane
    import y2r_pkg::*;
(
    input  logic       i_clk,
    input  logic [7:0] i_luma,
    input  logic [7:0] i_cb,
    input  logic [7:0] i_cr,
    output t_rgb       o_rgb
);

    logic [21:0] r_p_yrb, n_p_yrb;
    logic [22:0] r_p_yg,  n_p_yg;
    logic [21:0] r_p_vr,  n_p_vr;
    logic [22:0] r_p_ub,  n_p_ub;

    t_num        r_nr, n_nr;
    t_num        r_nb, n_nb;
    logic [22:0] r_yg2;

    logic [7:0]  r_r3, n_r3;
    logic [7:0]  r_b3, n_b3;
    logic [22:0] r_yg3;

    t_num        r_ng, n_ng;
    logic [7:0]  r_r4, r_b4;
    logic [20:0] n_mr;
    logic [18:0] n_mb;

    t_rgb        r_rgb, n_rgb;

    always_comb begin
        // stage 1: coefficient products
        n_p_yrb = 22'(KY_RB) * 22'(i_luma);
        n_p_yg  = 23'(KY_G) * 23'(i_luma);
        n_p_vr  = 22'(KV_R) * 22'(i_cr);
        n_p_ub  = 23'(KU_B) * 23'(i_cb);
        // stage 2: red and blue numerators
        n_nr = $signed({2'b00, r_p_yrb}) + $signed({2'b00, r_p_vr}) - OFF_R;
        n_nb = $signed({2'b00, r_p_yrb}) + $signed({1'b0, r_p_ub}) - OFF_B;
        // stage 3: saturated quotients
        n_r3 = sat_div(r_nr);
        n_b3 = sat_div(r_nb);
        // stage 4: green numerator from clamped red and blue
        n_mr = 21'(KR_G) * 21'(r_r3);
        n_mb = 19'(KB_G) * 19'(r_b3);
        n_ng = $signed({1'b0, r_yg3}) - OFF_G
             - $signed({3'b000, n_mr}) - $signed({5'b00000, n_mb});
        // stage 5: green quotient
        n_rgb.r = r_r4;
        n_rgb.g = sat_div(r_ng);
        n_rgb.b = r_b4;
    end

    always_ff @(posedge i_clk) begin
        r_p_yrb <= n_p_yrb;
        r_p_yg  <= n_p_yg;
        r_p_vr  <= n_p_vr;
        r_p_ub  <= n_p_ub;
        r_nr    <= n_nr;
        r_nb    <= n_nb;
        r_yg2   <= r_p_yg;
        r_r3    <= n_r3;
        r_b3    <= n_b3;
        r_yg3   <= r_yg2;
        r_ng    <= n_ng;
        r_r4    <= r_r3;
        r_b4    <= r_b3;
        r_rgb   <= n_rgb;
    end

    assign o_rgb = r_rgb;

endmodule

// File: design/y2r_merge.sv
// Output stage: joins the two lane pixels into one result and drives the strobe.
`timescale 1ns / 1ps
module y2r_merge
    import y2r_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    input  t_rgb       i_left,
    input  t_rgb       i_right,
    output logic       o_strobe,
    output t_rgb       o_left,
    output t_rgb       o_right
);

    logic r_strobe, n_strobe;
    t_rgb r_left, r_right;

    assign n_strobe = i_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
    end

    // payload loads only with a live transaction so a result stays put between strobes
    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_left  <= i_left;
            r_right <= i_right;
        end
    end

    assign o_strobe = r_strobe;
    assign o_left   = r_left;
    assign o_right  = r_right;

endmodule

// File: design/yuv420_pixel_pair_to_rgb_unit.sv
// Top level: YUV 4:2:0 pixel pair to two RGB888 pixels, two lanes and an output stage.
//
// Usage:
//   Input: drive i_luma_first, i_luma_second, i_chroma_blue, i_chroma_red and
//   raise start; a transaction is taken at each rising edge with start high
//   and busy low. busy is high only while reset is applied and the cycle
//   after, so one pixel pair is taken every clock.
//   Output: each result sits on the o_* pixel ports for one cycle with
//   o_strobe high; there is no back-pressure, the receiver must take it.
//   Path: from the accepting edge the result passes the five lane stages
//   (products, numerators, red/blue quotient, green numerator, green
//   quotient) and then one output register before the strobe cycle.
//   Throughput: 1 pair per cycle, each lane is fully pipelined.
//   Divide by 10000 is a reciprocal multiply after a range clamp.
//   Reset (synchronous, active low) clears the valid pipeline and the strobe;
//   transactions in flight are dropped.
`timescale 1ns / 1ps
module yuv420_pixel_pair_to_rgb_unit
    import y2r_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_luma_first,
    input  logic [7:0] i_luma_second,
    input  logic [7:0] i_chroma_blue,
    input  logic [7:0] i_chroma_red,
    output logic       o_strobe,
    output logic [7:0] o_red_first,
    output logic [7:0] o_green_first,
    output logic [7:0] o_blue_first,
    output logic [7:0] o_red_second,
    output logic [7:0] o_green_second,
    output logic [7:0] o_blue_second
);

    logic                r_rdy;
    logic [LANE_LAT-1:0] r_vld, n_vld;
    logic                accept;
    t_rgb                left_px, right_px, out_left, out_right;

    assign busy   = ~r_rdy;
    assign accept = start & ~busy;
    assign n_vld  = {r_vld[LANE_LAT-2:0], accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= 1'b0;
            r_vld <= '0;
        end else begin
            r_rdy <= 1'b1;
            r_vld <= n_vld;
        end
    end

    y2r_lane u_lane_first (
        .i_clk  (i_clk),
        .i_luma (i_luma_first),
        .i_cb   (i_chroma_blue),
        .i_cr   (i_chroma_red),
        .o_rgb  (left_px)
    );

    y2r_lane u_lane_second (
        .i_clk  (i_clk),
        .i_luma (i_luma_second),
        .i_cb   (i_chroma_blue),
        .i_cr   (i_chroma_red),
        .o_rgb  (right_px)
    );

    y2r_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_vld[LANE_LAT-1]),
        .i_left   (left_px),
        .i_right  (right_px),
        .o_strobe (o_strobe),
        .o_left   (out_left),
        .o_right  (out_right)
    );

    assign o_red_first    = out_left.r;
    assign o_green_first  = out_left.g;
    assign o_blue_first   = out_left.b;
    assign o_red_second   = out_right.r;
    assign o_green_second = out_right.g;
    assign o_blue_second  = out_right.b;

`ifndef SYNTH
    a_strobe_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, LANE_LAT + 1))
        else $error("strobe without matching transaction");

    a_accept_gives_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(LANE_LAT + 1) o_strobe)
        else $error("transaction produced no result");

    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy raised outside reset");
`endif

endmodule

// File: bench/yuv420_pixel_pair_to_rgb_check.sv
// Checker: predicts each pixel pair's RGB output and compares it against the pixel ports at each strobe.
`timescale 1ns / 1ps
module yuv420_pixel_pair_to_rgb_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic [7:0] i_luma_first,
    input  logic [7:0] i_luma_second,
    input  logic [7:0] i_chroma_blue,
    input  logic [7:0] i_chroma_red,
    input  logic       i_strobe,
    input  logic [7:0] i_red_first,
    input  logic [7:0] i_green_first,
    input  logic [7:0] i_blue_first,
    input  logic [7:0] i_red_second,
    input  logic [7:0] i_green_second,
    input  logic [7:0] i_blue_second,
    output int         o_fail_count,
    output int         o_pending
);

    // coefficients scaled by 10000
    localparam longint LUMA_RB_GAIN   = 11644;
    localparam longint LUMA_G_GAIN    = 19837;
    localparam longint CR_TO_RED      = 15938;
    localparam longint CB_TO_BLUE     = 20238;
    localparam longint RED_TO_GREEN   = 5094;
    localparam longint BLUE_TO_GREEN  = 1942;
    localparam longint RED_OFFSET     = 2221300;
    localparam longint BLUE_OFFSET    = 2771300;
    localparam longint GREEN_OFFSET   = 311710;
    localparam longint FIXED_SCALE    = 10000;
    localparam longint CHANNEL_TOP    = 255;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb_pixel;

    typedef struct packed {
        t_rgb_pixel first;
        t_rgb_pixel second;
    } t_rgb_pair;

    t_rgb_pair expected_pairs[$];

    function automatic longint scale_and_clamp(input longint num);
        longint quot;
        if (num < 0) begin
            return 0;
        end
        quot = num / FIXED_SCALE;
        return (quot > CHANNEL_TOP) ? CHANNEL_TOP : quot;
    endfunction

    function automatic t_rgb_pixel yuv_to_rgb(input logic [7:0] luma,
                                              input logic [7:0] cb,
                                              input logic [7:0] cr);
        longint y;
        longint u;
        longint v;
        longint red;
        longint blue;
        longint green;
        t_rgb_pixel px;
        y    = longint'(luma);
        u    = longint'(cb);
        v    = longint'(cr);
        red  = scale_and_clamp(LUMA_RB_GAIN * y + CR_TO_RED * v - RED_OFFSET);
        blue = scale_and_clamp(LUMA_RB_GAIN * y + CB_TO_BLUE * u - BLUE_OFFSET);
        // green uses the already saturated red and blue
        green = scale_and_clamp(LUMA_G_GAIN * y - GREEN_OFFSET
                                - RED_TO_GREEN * red - BLUE_TO_GREEN * blue);
        px.red   = red[7:0];
        px.green = green[7:0];
        px.blue  = blue[7:0];
        return px;
    endfunction

    task automatic check_channel(input string name, input logic [7:0] exp_val,
                                 input logic [7:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rgb_pair exp_pair;
        if (i_strobe === 1'b1) begin
            if (expected_pairs.size() == 0) begin
                $error("result strobe with no transaction outstanding");
                o_fail_count++;
            end else begin
                exp_pair = expected_pairs.pop_front();
                check_channel("red_first",    exp_pair.first.red,    i_red_first);
                check_channel("green_first",  exp_pair.first.green,  i_green_first);
                check_channel("blue_first",   exp_pair.first.blue,   i_blue_first);
                check_channel("red_second",   exp_pair.second.red,   i_red_second);
                check_channel("green_second", exp_pair.second.green, i_green_second);
                check_channel("blue_second",  exp_pair.second.blue,  i_blue_second);
            end
        end
        if (i_rst_n && i_start && !i_busy) begin
            exp_pair.first  = yuv_to_rgb(i_luma_first, i_chroma_blue, i_chroma_red);
            exp_pair.second = yuv_to_rgb(i_luma_second, i_chroma_blue, i_chroma_red);
            expected_pairs.push_back(exp_pair);
        end
        o_pending = expected_pairs.size();
    end

endmodule

// File: bench/yuv420_pixel_pair_to_rgb_unit_test.sv
// Testbench top: drives pixel pairs into the converter and reports the verdict.
`timescale 1ns / 1ps
module yuv420_pixel_pair_to_rgb_unit_test;

    localparam int RESET_CYCLES = 7;
    localparam int PHASE_PAIRS  = 100;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [7:0] i_luma_first;
    logic [7:0] i_luma_second;
    logic [7:0] i_chroma_blue;
    logic [7:0] i_chroma_red;
    logic       o_strobe;
    logic [7:0] o_red_first;
    logic [7:0] o_green_first;
    logic [7:0] o_blue_first;
    logic [7:0] o_red_second;
    logic [7:0] o_green_second;
    logic [7:0] o_blue_second;
    int         fail_count;
    int         pending_count;
    int         cycle_count;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    yuv420_pixel_pair_to_rgb_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_luma_first   (i_luma_first),
        .i_luma_second  (i_luma_second),
        .i_chroma_blue  (i_chroma_blue),
        .i_chroma_red   (i_chroma_red),
        .o_strobe       (o_strobe),
        .o_red_first    (o_red_first),
        .o_green_first  (o_green_first),
        .o_blue_first   (o_blue_first),
        .o_red_second   (o_red_second),
        .o_green_second (o_green_second),
        .o_blue_second  (o_blue_second)
    );

    yuv420_pixel_pair_to_rgb_check u_color_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_luma_first   (i_luma_first),
        .i_luma_second  (i_luma_second),
        .i_chroma_blue  (i_chroma_blue),
        .i_chroma_red   (i_chroma_red),
        .i_strobe       (o_strobe),
        .i_red_first    (o_red_first),
        .i_green_first  (o_green_first),
        .i_blue_first   (o_blue_first),
        .i_red_second   (o_red_second),
        .i_green_second (o_green_second),
        .i_blue_second  (o_blue_second),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    // biased toward the saturation corners
    function automatic logic [7:0] pick_sample();
        int sel;
        sel = $urandom_range(7);
        if (sel == 0) begin
            return 8'd0;
        end else if (sel == 1) begin
            return 8'd255;
        end
        return 8'($urandom_range(255));
    endfunction

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_pair(input logic [7:0] y0, input logic [7:0] y1,
                             input logic [7:0] cb, input logic [7:0] cr);
        i_luma_first  = y0;
        i_luma_second = y1;
        i_chroma_blue = cb;
        i_chroma_red  = cr;
        start         = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start         = 1'b0;
            i_luma_first  = 8'($urandom_range(255));
            i_luma_second = 8'($urandom_range(255));
            i_chroma_blue = 8'($urandom_range(255));
            i_chroma_red  = 8'($urandom_range(255));
            @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        start = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int         idle_pct[4];
        logic [7:0] bit_k;
        idle_pct      = '{0, 75, 0, 18};
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_luma_first  = 8'd0;
        i_luma_second = 8'd0;
        i_chroma_blue = 8'd0;
        i_chroma_red  = 8'd0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // chroma corners with opposite luma extremes in the two lanes
        send_pair(8'd0,   8'd255, 8'd0,   8'd0);
        send_pair(8'd0,   8'd255, 8'd0,   8'd255);
        send_pair(8'd0,   8'd255, 8'd255, 8'd0);
        send_pair(8'd0,   8'd255, 8'd255, 8'd255);
        send_pair(8'd255, 8'd0,   8'd0,   8'd0);
        send_pair(8'd255, 8'd0,   8'd0,   8'd255);
        send_pair(8'd255, 8'd0,   8'd255, 8'd0);
        send_pair(8'd255, 8'd0,   8'd255, 8'd255);
        // video black and white levels, neutral chroma
        send_pair(8'd16,  8'd235, 8'd128, 8'd128);
        // red numerator straddling zero
        send_pair(8'd15,  8'd16,  8'd128, 8'd128);
        // red quotient right at 255 and just over
        send_pair(8'd61,  8'd62,  8'd128, 8'd255);
        send_pair(8'd128, 8'd127, 8'd200, 8'd60);
        for (int k = 0; k < 8; k++) begin
            bit_k = 8'd1 << k;
            send_pair(bit_k, ~bit_k, bit_k, ~bit_k);
        end
        drain_results();

        foreach (idle_pct[p]) begin
            repeat (PHASE_PAIRS) begin
                idle_gap(idle_pct[p]);
                send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample());
            end
            // hold off until every outstanding transaction has returned
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
